// ----- hw/rtl/ucrd_pkg.sv -----
// Types, request codes and buffer constants for the USB control request decoder.
`timescale 1ns / 1ps
`default_nettype none

package ucrd_pkg;

	// bmRequestType bits 6:5
	localparam logic [1:0] KIND_STANDARD = 2'd0;
	localparam logic [1:0] KIND_CLASS    = 2'd1;

	// standard requests
	localparam logic [7:0] REQ_GET_STATUS        = 8'h00;
	localparam logic [7:0] REQ_SET_ADDRESS       = 8'h05;
	localparam logic [7:0] REQ_GET_DESCRIPTOR    = 8'h06;
	localparam logic [7:0] REQ_GET_CONFIGURATION = 8'h08;
	localparam logic [7:0] REQ_SET_CONFIGURATION = 8'h09;
	localparam logic [7:0] REQ_GET_INTERFACE     = 8'h0A;
	localparam logic [7:0] REQ_SET_INTERFACE     = 8'h0B;

	// CDC ACM class requests
	localparam logic [7:0] REQ_SEND_ENCAP        = 8'h00;
	localparam logic [7:0] REQ_GET_ENCAP         = 8'h01;
	localparam logic [7:0] REQ_SET_LINE_CODING   = 8'h20;
	localparam logic [7:0] REQ_GET_LINE_CODING   = 8'h21;
	localparam logic [7:0] REQ_SET_CTRL_LINE     = 8'h22;
	localparam logic [7:0] REQ_SEND_BREAK        = 8'h23;

	// descriptor types (wValue high byte)
	localparam logic [7:0] DESC_DEVICE    = 8'h01;
	localparam logic [7:0] DESC_CONFIG    = 8'h02;
	localparam logic [7:0] DESC_STRING    = 8'h03;
	localparam logic [7:0] DESC_QUALIFIER = 8'h06;
	localparam logic [7:0] NUM_STRINGS    = 8'd4;

	// response buffer ids
	localparam logic [3:0] BUF_NONE        = 4'd0;
	localparam logic [3:0] BUF_USB_STATUS  = 4'd1;
	localparam logic [3:0] BUF_DEV_STATUS  = 4'd2;
	localparam logic [3:0] BUF_DEV_DESC    = 4'd3;
	localparam logic [3:0] BUF_CONFIG      = 4'd4;
	localparam logic [3:0] BUF_QUALIFIER   = 4'd5;
	localparam logic [3:0] BUF_STRING0     = 4'd6;
	localparam logic [3:0] BUF_INTERFACE   = 4'd10;
	localparam logic [3:0] BUF_LINE_CODING = 4'd11;

	// buffer sizes in bytes
	localparam logic [6:0] SIZE_USB_STATUS  = 7'd2;
	localparam logic [6:0] SIZE_DEV_DESC    = 7'd18;
	localparam logic [6:0] SIZE_CONFIG      = 7'd67;
	localparam logic [6:0] SIZE_QUALIFIER   = 7'd10;
	localparam logic [6:0] SIZE_ONE_BYTE    = 7'd1;
	localparam logic [6:0] SIZE_LINE_CODING = 7'd7;

	typedef struct packed {
		logic [6:0] dev_addr;
		logic       config_sel;
		logic [7:0] alt_setting;
	} dev_state_t;

	typedef struct packed {
		logic       stall;
		logic [3:0] buffer_id;
		logic       prime_out;
		logic [6:0] out_length;
		logic       prime_in;
		logic [6:0] in_length;
		logic       start_eps;
	} reply_t;

	// string descriptor sizes, index 0..3
	function automatic logic [6:0] string_size(input logic [1:0] idx);
		logic [6:0] sz;
		case (idx)
			2'd0:    sz = 7'd4;
			2'd1:    sz = 7'd10;
			2'd2:    sz = 7'd12;
			default: sz = 7'd16;
		endcase
		return sz;
	endfunction

	// min(asked, size)
	function automatic logic [6:0] clamp_len(input logic [15:0] asked, input logic [6:0] size);
		return (asked > {9'd0, size}) ? size : asked[6:0];
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/ucrd_decode.sv -----
// Combinational decode of one setup packet against the current device state.
`timescale 1ns / 1ps
`default_nettype none

module ucrd_decode (
	input  wire logic [7:0]         request_type,
	input  wire logic [7:0]         request_code,
	input  wire logic [15:0]        request_value,
	input  wire logic [15:0]        request_length,
	input  wire ucrd_pkg::dev_state_t state_cur,
	output ucrd_pkg::dev_state_t    state_nxt,
	output ucrd_pkg::reply_t        reply
);

	logic [1:0] kind;
	logic [7:0] dtype;
	logic [7:0] sidx;
	logic       stall;
	logic       start;
	logic [3:0] buf_id;
	logic [6:0] olen;
	logic [6:0] ilen;

	assign kind  = request_type[6:5];
	assign dtype = request_value[15:8];
	assign sidx  = request_value[7:0];

	// request decode and state update
	always_comb begin
		stall     = 1'b0;
		start     = 1'b0;
		buf_id    = ucrd_pkg::BUF_NONE;
		olen      = 7'd0;
		ilen      = 7'd0;
		state_nxt = state_cur;
		if (kind == ucrd_pkg::KIND_STANDARD) begin
			case (request_code)
				ucrd_pkg::REQ_GET_STATUS: begin
					buf_id = ucrd_pkg::BUF_USB_STATUS;
					ilen   = ucrd_pkg::clamp_len(request_length, ucrd_pkg::SIZE_USB_STATUS);
				end
				ucrd_pkg::REQ_SET_ADDRESS: begin
					state_nxt.dev_addr = request_value[6:0];
					buf_id = ucrd_pkg::BUF_DEV_STATUS;
				end
				ucrd_pkg::REQ_GET_DESCRIPTOR: begin
					if (dtype == ucrd_pkg::DESC_DEVICE) begin
						buf_id = ucrd_pkg::BUF_DEV_DESC;
						ilen   = ucrd_pkg::clamp_len(request_length, ucrd_pkg::SIZE_DEV_DESC);
					end else if (dtype == ucrd_pkg::DESC_CONFIG) begin
						buf_id = ucrd_pkg::BUF_CONFIG;
						ilen   = ucrd_pkg::clamp_len(request_length, ucrd_pkg::SIZE_CONFIG);
					end else if (dtype == ucrd_pkg::DESC_QUALIFIER) begin
						buf_id = ucrd_pkg::BUF_QUALIFIER;
						ilen   = ucrd_pkg::clamp_len(request_length, ucrd_pkg::SIZE_QUALIFIER);
					end else if (dtype == ucrd_pkg::DESC_STRING && sidx < ucrd_pkg::NUM_STRINGS) begin
						buf_id = ucrd_pkg::BUF_STRING0 + {2'd0, sidx[1:0]};
						ilen   = ucrd_pkg::clamp_len(request_length,
							ucrd_pkg::string_size(sidx[1:0]));
					end else begin
						stall = 1'b1;
					end
				end
				ucrd_pkg::REQ_GET_CONFIGURATION: begin
					buf_id = ucrd_pkg::BUF_DEV_STATUS;
					ilen   = ucrd_pkg::clamp_len(request_length, ucrd_pkg::SIZE_ONE_BYTE);
				end
				ucrd_pkg::REQ_SET_CONFIGURATION: begin
					if (request_value > 16'd1) begin
						stall = 1'b1;
					end else begin
						start = request_value[0];
						state_nxt.config_sel = request_value[0];
						buf_id = ucrd_pkg::BUF_DEV_STATUS;
					end
				end
				ucrd_pkg::REQ_GET_INTERFACE: begin
					buf_id = ucrd_pkg::BUF_INTERFACE;
					ilen   = ucrd_pkg::clamp_len(request_length, ucrd_pkg::SIZE_ONE_BYTE);
				end
				ucrd_pkg::REQ_SET_INTERFACE: begin
					state_nxt.alt_setting = request_value[7:0];
					buf_id = ucrd_pkg::BUF_INTERFACE;
				end
				default: stall = 1'b1;
			endcase
		end else if (kind == ucrd_pkg::KIND_CLASS) begin
			case (request_code)
				ucrd_pkg::REQ_SEND_ENCAP, ucrd_pkg::REQ_GET_ENCAP: begin
					buf_id = ucrd_pkg::BUF_NONE;
				end
				ucrd_pkg::REQ_SET_LINE_CODING: begin
					buf_id = ucrd_pkg::BUF_LINE_CODING;
					olen   = ucrd_pkg::SIZE_LINE_CODING;
				end
				ucrd_pkg::REQ_GET_LINE_CODING: begin
					buf_id = ucrd_pkg::BUF_LINE_CODING;
					ilen   = ucrd_pkg::SIZE_LINE_CODING;
				end
				ucrd_pkg::REQ_SET_CTRL_LINE, ucrd_pkg::REQ_SEND_BREAK: begin
					buf_id = ucrd_pkg::BUF_LINE_CODING;
				end
				default: stall = 1'b1;
			endcase
		end else begin
			// vendor and reserved
			stall = 1'b1;
		end
	end

	// a stall clears the reply and leaves state untouched (no state change was made above)
	always_comb begin
		reply.stall      = stall;
		reply.buffer_id  = stall ? ucrd_pkg::BUF_NONE : buf_id;
		reply.out_length = stall ? 7'd0 : olen;
		reply.in_length  = stall ? 7'd0 : ilen;
		reply.prime_out  = !stall && (olen != 7'd0);
		reply.prime_in   = !stall && (ilen != 7'd0);
		reply.start_eps  = !stall && start;
	end

endmodule

`default_nettype wire

// ----- hw/rtl/usb_control_request_decoder.sv -----
// Top level: input register, request decode, device state and result register.
`timescale 1ns / 1ps
`default_nettype none

// Decodes one USB setup packet per beat into a control-endpoint reply: stall,
// response buffer id, OUT/IN data stage primes and lengths (IN clamped to the
// buffer size), plus the device address, configuration and alternate setting
// after the request. An accepted beat lands in an input register, is decoded
// combinationally and is written to the result register when that register
// is empty or being read out. One beat is taken every cycle
// while the result side keeps up. The device state registers update when a
// beat moves into the result register, so each beat sees the effect of every
// beat before it. request_index is not used by any supported request.
module usb_control_request_decoder (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [3:0]  endpoint_num,
	input  wire logic [7:0]  request_type,
	input  wire logic [7:0]  request_code,
	input  wire logic [15:0] request_value,
	input  wire logic [15:0] request_index,
	input  wire logic [15:0] request_length,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [3:0]       reply_endpoint,
	output logic             stall_res,
	output logic [3:0]       buffer_id,
	output logic             prime_out,
	output logic [6:0]       out_length,
	output logic             prime_in,
	output logic [6:0]       in_length,
	output logic             start_data_endpoints,
	output logic [6:0]       device_address_now,
	output logic             configuration_now,
	output logic [7:0]       alt_setting_now
);

	logic        valid_s1;
	logic [3:0]  ep_s1;
	logic [7:0]  type_s1;
	logic [7:0]  code_s1;
	logic [15:0] value_s1;
	logic [15:0] length_s1;

	logic             valid_s2;
	logic [3:0]       ep_s2;
	ucrd_pkg::reply_t reply_s2;

	ucrd_pkg::dev_state_t state_q;
	ucrd_pkg::dev_state_t state_nxt;
	ucrd_pkg::reply_t     reply_d;
	logic                 adv_s2;
	logic                 in_fire;

	// flow control
	assign adv_s2   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv_s2;
	assign in_fire  = in_valid && in_ready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			ep_s1     <= endpoint_num;
			type_s1   <= request_type;
			code_s1   <= request_code;
			value_s1  <= request_value;
			length_s1 <= request_length;
		end
	end

	ucrd_decode u_decode (
		.request_type   (type_s1),
		.request_code   (code_s1),
		.request_value  (value_s1),
		.request_length (length_s1),
		.state_cur      (state_q),
		.state_nxt      (state_nxt),
		.reply          (reply_d)
	);

	// device state, committed as the beat moves to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (adv_s2) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			ep_s2    <= ep_s1;
			reply_s2 <= reply_d;
		end
	end

	assign out_valid            = valid_s2;
	assign reply_endpoint       = ep_s2;
	assign stall_res            = reply_s2.stall;
	assign buffer_id            = reply_s2.buffer_id;
	assign prime_out            = reply_s2.prime_out;
	assign out_length           = reply_s2.out_length;
	assign prime_in             = reply_s2.prime_in;
	assign in_length            = reply_s2.in_length;
	assign start_data_endpoints = reply_s2.start_eps;
	assign device_address_now   = state_q.dev_addr;
	assign configuration_now    = state_q.config_sel;
	assign alt_setting_now      = state_q.alt_setting;

	// a stalled reply carries no buffer and primes nothing
	a_stall_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && reply_s2.stall) |->
		(!reply_s2.prime_in && !reply_s2.prime_out && reply_s2.buffer_id == ucrd_pkg::BUF_NONE
		 && !reply_s2.start_eps))
		else $error("stalled reply not cleared");

	// primes follow the stage lengths
	a_prime_len: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> ((reply_s2.prime_in == (reply_s2.in_length != 7'd0)) &&
		              (reply_s2.prime_out == (reply_s2.out_length != 7'd0))))
		else $error("prime flag disagrees with length");

	// endpoint start only with configuration 1 selected
	a_start_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && reply_s2.start_eps) |-> state_q.config_sel)
		else $error("start without configuration 1");

	// device state moves only when a beat enters the result register
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv_s2 |=> $stable(state_q))
		else $error("device state changed without a beat");

	// no new beat is taken while a full input register cannot drain
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !out_ready && valid_s1) |-> !in_ready)
		else $error("input register overrun");

endmodule

`default_nettype wire

// ----- dv/ucrd_reply_checker.sv -----
// Reply checker: predicts each setup packet's reply and compares it on the result channel.
`timescale 1ns / 1ps

module ucrd_reply_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [3:0]  endpoint_num,
	input  logic [7:0]  request_type,
	input  logic [7:0]  request_code,
	input  logic [15:0] request_value,
	input  logic [15:0] request_length,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [3:0]  reply_endpoint,
	input  logic        stall_res,
	input  logic [3:0]  buffer_id,
	input  logic        prime_out,
	input  logic [6:0]  out_length,
	input  logic        prime_in,
	input  logic [6:0]  in_length,
	input  logic        start_data_endpoints,
	input  logic [6:0]  device_address_now,
	input  logic        configuration_now,
	input  logic [7:0]  alt_setting_now,
	output int          mismatches,
	output int          outstanding,
	output int          replies_checked
);

	typedef struct {
		logic [3:0] ep;
		logic       stall;
		logic [3:0] buf_id;
		logic       p_out;
		logic [6:0] o_len;
		logic       p_in;
		logic [6:0] i_len;
		logic       start;
		logic [6:0] addr;
		logic       cfg;
		logic [7:0] alt;
	} setup_reply_t;

	// predicted device state
	logic [6:0] dev_addr;
	logic       cfg_sel;
	logic [7:0] alt_set;

	setup_reply_t reply_queue[$];

	// bytes actually sent: the host's wLength, capped at the buffer size
	function automatic logic [6:0] fit_length(input logic [15:0] asked, input logic [6:0] limit);
		if (asked < {9'd0, limit})
			return asked[6:0];
		return limit;
	endfunction

	function automatic logic [6:0] string_bytes(input logic [7:0] sidx);
		logic [6:0] n;
		case (sidx)
			8'd0:    n = 7'd4;
			8'd1:    n = 7'd10;
			8'd2:    n = 7'd12;
			default: n = 7'd16;
		endcase
		return n;
	endfunction

	// decode one setup packet and advance the predicted device state
	function automatic setup_reply_t decode_request(input logic [3:0] ep,
			input logic [7:0] rtype, input logic [7:0] code,
			input logic [15:0] value, input logic [15:0] length);
		setup_reply_t r;
		logic       stall;
		logic       start;
		logic [3:0] buf_id;
		logic [6:0] olen;
		logic [6:0] ilen;
		logic [7:0] dtype;
		logic [7:0] sidx;
		stall  = 1'b0;
		start  = 1'b0;
		buf_id = ucrd_pkg::BUF_NONE;
		olen   = 7'd0;
		ilen   = 7'd0;
		dtype  = value[15:8];
		sidx   = value[7:0];
		case (rtype[6:5])
			ucrd_pkg::KIND_STANDARD: begin
				case (code)
					ucrd_pkg::REQ_GET_STATUS: begin
						buf_id = ucrd_pkg::BUF_USB_STATUS;
						ilen   = fit_length(length, ucrd_pkg::SIZE_USB_STATUS);
					end
					ucrd_pkg::REQ_SET_ADDRESS: begin
						dev_addr = value[6:0];
						buf_id   = ucrd_pkg::BUF_DEV_STATUS;
					end
					ucrd_pkg::REQ_GET_DESCRIPTOR: begin
						if (dtype == ucrd_pkg::DESC_DEVICE) begin
							buf_id = ucrd_pkg::BUF_DEV_DESC;
							ilen   = fit_length(length, ucrd_pkg::SIZE_DEV_DESC);
						end else if (dtype == ucrd_pkg::DESC_CONFIG) begin
							buf_id = ucrd_pkg::BUF_CONFIG;
							ilen   = fit_length(length, ucrd_pkg::SIZE_CONFIG);
						end else if (dtype == ucrd_pkg::DESC_QUALIFIER) begin
							buf_id = ucrd_pkg::BUF_QUALIFIER;
							ilen   = fit_length(length, ucrd_pkg::SIZE_QUALIFIER);
						end else if (dtype == ucrd_pkg::DESC_STRING &&
								sidx < ucrd_pkg::NUM_STRINGS) begin
							buf_id = ucrd_pkg::BUF_STRING0 + sidx[3:0];
							ilen   = fit_length(length, string_bytes(sidx));
						end else begin
							stall = 1'b1;
						end
					end
					ucrd_pkg::REQ_GET_CONFIGURATION: begin
						buf_id = ucrd_pkg::BUF_DEV_STATUS;
						ilen   = fit_length(length, ucrd_pkg::SIZE_ONE_BYTE);
					end
					ucrd_pkg::REQ_SET_CONFIGURATION: begin
						if (value > 16'd1) begin
							stall = 1'b1;
						end else begin
							start   = value[0];
							cfg_sel = value[0];
							buf_id  = ucrd_pkg::BUF_DEV_STATUS;
						end
					end
					ucrd_pkg::REQ_GET_INTERFACE: begin
						buf_id = ucrd_pkg::BUF_INTERFACE;
						ilen   = fit_length(length, ucrd_pkg::SIZE_ONE_BYTE);
					end
					ucrd_pkg::REQ_SET_INTERFACE: begin
						alt_set = value[7:0];
						buf_id  = ucrd_pkg::BUF_INTERFACE;
					end
					default: stall = 1'b1;
				endcase
			end
			ucrd_pkg::KIND_CLASS: begin
				case (code)
					ucrd_pkg::REQ_SEND_ENCAP, ucrd_pkg::REQ_GET_ENCAP: ;
					ucrd_pkg::REQ_SET_LINE_CODING: begin
						buf_id = ucrd_pkg::BUF_LINE_CODING;
						olen   = ucrd_pkg::SIZE_LINE_CODING;
					end
					ucrd_pkg::REQ_GET_LINE_CODING: begin
						buf_id = ucrd_pkg::BUF_LINE_CODING;
						ilen   = ucrd_pkg::SIZE_LINE_CODING;
					end
					ucrd_pkg::REQ_SET_CTRL_LINE, ucrd_pkg::REQ_SEND_BREAK:
						buf_id = ucrd_pkg::BUF_LINE_CODING;
					default: stall = 1'b1;
				endcase
			end
			// vendor and reserved
			default: stall = 1'b1;
		endcase

		if (stall) begin
			buf_id = ucrd_pkg::BUF_NONE;
			olen   = 7'd0;
			ilen   = 7'd0;
			start  = 1'b0;
		end

		r.ep     = ep;
		r.stall  = stall;
		r.buf_id = buf_id;
		r.p_out  = (olen != 7'd0);
		r.o_len  = olen;
		r.p_in   = (ilen != 7'd0);
		r.i_len  = ilen;
		r.start  = start;
		r.addr   = dev_addr;
		r.cfg    = cfg_sel;
		r.alt    = alt_set;
		return r;
	endfunction

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	// watch both channels; the result side is handled first on a shared edge
	always @(posedge clk or negedge arst_n) begin
		setup_reply_t exp;
		if (!arst_n) begin
			dev_addr        = 7'd0;
			cfg_sel         = 1'b0;
			alt_set         = 8'd0;
			mismatches      = 0;
			replies_checked = 0;
			reply_queue.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (reply_queue.size() == 0) begin
					$error("reply beat with no request waiting");
					mismatches++;
				end else begin
					exp = reply_queue.pop_front();
					replies_checked++;
					check_field("reply_endpoint", exp.ep, reply_endpoint);
					check_field("stall_res", exp.stall, stall_res);
					check_field("buffer_id", exp.buf_id, buffer_id);
					check_field("prime_out", exp.p_out, prime_out);
					check_field("out_length", exp.o_len, out_length);
					check_field("prime_in", exp.p_in, prime_in);
					check_field("in_length", exp.i_len, in_length);
					check_field("start_data_endpoints", exp.start, start_data_endpoints);
					check_field("device_address_now", exp.addr, device_address_now);
					check_field("configuration_now", exp.cfg, configuration_now);
					check_field("alt_setting_now", exp.alt, alt_setting_now);
				end
			end
			if (in_valid && in_ready)
				reply_queue.push_back(decode_request(endpoint_num, request_type,
					request_code, request_value, request_length));
		end
		outstanding = reply_queue.size();
	end

endmodule

// ----- dv/usb_control_request_decoder_tb.sv -----
// Testbench top: setup packet stimulus, reply channel back-pressure and the verdict.
`timescale 1ns / 1ps

module usb_control_request_decoder_tb;

	localparam logic [1:0] KIND_VENDOR   = 2'd2;
	localparam logic [1:0] KIND_RESERVED = 2'd3;
	localparam logic       DIR_OUT       = 1'b0;
	localparam logic       DIR_IN        = 1'b1;
	localparam int         RANDOM_PER_PHASE = 250;
	// standard request the block does not support
	localparam logic [7:0] REQ_CLEAR_FEATURE  = 8'h01;
	localparam logic [7:0] REQ_CLASS_UNKNOWN  = 8'hFF;
	localparam logic [7:0] DESC_UNKNOWN       = 8'hFF;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [3:0]  endpoint_num;
	logic [7:0]  request_type;
	logic [7:0]  request_code;
	logic [15:0] request_value;
	logic [15:0] request_index;
	logic [15:0] request_length;
	logic        out_valid;
	logic        out_ready;
	logic [3:0]  reply_endpoint;
	logic        stall_res;
	logic [3:0]  buffer_id;
	logic        prime_out;
	logic [6:0]  out_length;
	logic        prime_in;
	logic [6:0]  in_length;
	logic        start_data_endpoints;
	logic [6:0]  device_address_now;
	logic        configuration_now;
	logic [7:0]  alt_setting_now;

	int mismatches;
	int outstanding;
	int replies_checked;
	int packets_sent = 0;
	int sender_idle_pct = 0;
	int recv_idle_pct = 0;

	usb_control_request_decoder uut (
		.clk                  (clk),
		.arst_n               (arst_n),
		.in_valid             (in_valid),
		.in_ready             (in_ready),
		.endpoint_num         (endpoint_num),
		.request_type         (request_type),
		.request_code         (request_code),
		.request_value        (request_value),
		.request_index        (request_index),
		.request_length       (request_length),
		.out_valid            (out_valid),
		.out_ready            (out_ready),
		.reply_endpoint       (reply_endpoint),
		.stall_res            (stall_res),
		.buffer_id            (buffer_id),
		.prime_out            (prime_out),
		.out_length           (out_length),
		.prime_in             (prime_in),
		.in_length            (in_length),
		.start_data_endpoints (start_data_endpoints),
		.device_address_now   (device_address_now),
		.configuration_now    (configuration_now),
		.alt_setting_now      (alt_setting_now)
	);

	ucrd_reply_checker checker_i (
		.clk                  (clk),
		.arst_n               (arst_n),
		.in_valid             (in_valid),
		.in_ready             (in_ready),
		.endpoint_num         (endpoint_num),
		.request_type         (request_type),
		.request_code         (request_code),
		.request_value        (request_value),
		.request_length       (request_length),
		.out_valid            (out_valid),
		.out_ready            (out_ready),
		.reply_endpoint       (reply_endpoint),
		.stall_res            (stall_res),
		.buffer_id            (buffer_id),
		.prime_out            (prime_out),
		.out_length           (out_length),
		.prime_in             (prime_in),
		.in_length            (in_length),
		.start_data_endpoints (start_data_endpoints),
		.device_address_now   (device_address_now),
		.configuration_now    (configuration_now),
		.alt_setting_now      (alt_setting_now),
		.mismatches           (mismatches),
		.outstanding          (outstanding),
		.replies_checked      (replies_checked)
	);

	// 4 ns clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// run limit
	initial begin
		#2_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// reply side back-pressure, redrawn every falling edge
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	function automatic logic [7:0] make_type(input logic dir, input logic [1:0] kind);
		return {dir, kind, 5'd0};
	endfunction

	// present one setup beat after random idle cycles; returns on the falling edge after accept
	task automatic send_setup(input logic [3:0] ep, input logic [7:0] rtype,
			input logic [7:0] code, input logic [15:0] value,
			input logic [15:0] index, input logic [15:0] length);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid       <= 1'b1;
		endpoint_num   <= ep;
		request_type   <= rtype;
		request_code   <= code;
		request_value  <= value;
		request_index  <= index;
		request_length <= length;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
		packets_sent++;
	endtask

	// hold the sender off until every reply is back
	task automatic drain_replies();
		in_valid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0)
			@(negedge clk);
	endtask

	// mostly well-formed requests with random content, some pure noise
	task automatic send_random_setup();
		logic [1:0]  kind;
		logic [7:0]  code;
		logic [15:0] value;
		logic [15:0] length;
		int          roll;
		roll   = $urandom_range(99);
		value  = 16'($urandom_range(16'hFFFF));
		case ($urandom_range(9))
			0, 1, 2, 3, 4: length = 16'($urandom_range(80));
			5, 6, 7:       length = 16'($urandom_range(3));
			default:       length = 16'($urandom_range(16'hFFFF));
		endcase
		if (roll < 12) begin
			send_setup(4'($urandom_range(15)), 8'($urandom_range(255)),
				8'($urandom_range(255)), 16'($urandom_range(16'hFFFF)),
				16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)));
			return;
		end
		if (roll < 72)
			kind = ucrd_pkg::KIND_STANDARD;
		else if (roll < 94)
			kind = ucrd_pkg::KIND_CLASS;
		else
			kind = $urandom_range(1) ? KIND_VENDOR : KIND_RESERVED;

		if (kind == ucrd_pkg::KIND_CLASS) begin
			case ($urandom_range(6))
				0:       code = ucrd_pkg::REQ_SEND_ENCAP;
				1:       code = ucrd_pkg::REQ_GET_ENCAP;
				2:       code = ucrd_pkg::REQ_SET_LINE_CODING;
				3:       code = ucrd_pkg::REQ_GET_LINE_CODING;
				4:       code = ucrd_pkg::REQ_SET_CTRL_LINE;
				5:       code = ucrd_pkg::REQ_SEND_BREAK;
				default: code = 8'($urandom_range(255));
			endcase
		end else begin
			case ($urandom_range(7))
				0:       code = ucrd_pkg::REQ_GET_STATUS;
				1:       code = ucrd_pkg::REQ_SET_ADDRESS;
				2:       code = ucrd_pkg::REQ_GET_DESCRIPTOR;
				3:       code = ucrd_pkg::REQ_GET_CONFIGURATION;
				4:       code = ucrd_pkg::REQ_SET_CONFIGURATION;
				5:       code = ucrd_pkg::REQ_GET_INTERFACE;
				6:       code = ucrd_pkg::REQ_SET_INTERFACE;
				default: code = 8'($urandom_range(255));
			endcase
			// shape wValue so descriptor and configuration requests mostly hit
			if (code == ucrd_pkg::REQ_GET_DESCRIPTOR && $urandom_range(9) < 8) begin
				case ($urandom_range(4))
					0:       value[15:8] = ucrd_pkg::DESC_DEVICE;
					1:       value[15:8] = ucrd_pkg::DESC_CONFIG;
					2:       value[15:8] = ucrd_pkg::DESC_QUALIFIER;
					default: value[15:8] = ucrd_pkg::DESC_STRING;
				endcase
				value[7:0] = 8'($urandom_range(4));
			end else if (code == ucrd_pkg::REQ_SET_CONFIGURATION && $urandom_range(9) < 8) begin
				value = 16'($urandom_range(2));
			end
		end
		send_setup(4'($urandom_range(15)), {1'($urandom_range(1)), kind, 5'($urandom_range(31))},
			code, value, 16'($urandom_range(16'hFFFF)), length);
	endtask

	// one of each request kind, the length extremes and every stall case
	task automatic send_directed_setups();
		send_setup(4'd0, make_type(DIR_IN, ucrd_pkg::KIND_STANDARD), ucrd_pkg::REQ_GET_STATUS,
			16'h0000, 16'h0000, 16'd0);
		send_setup(4'd15, make_type(DIR_IN, ucrd_pkg::KIND_STANDARD), ucrd_pkg::REQ_GET_STATUS,
			16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_setup(4'd1, make_type(DIR_OUT, ucrd_pkg::KIND_STANDARD), ucrd_pkg::REQ_SET_ADDRESS,
			16'h007F, 16'h0000, 16'd0);
		send_setup(4'd2, make_type(DIR_OUT, ucrd_pkg::KIND_STANDARD), ucrd_pkg::REQ_SET_ADDRESS,
			16'hFFFF, 16'h0000, 16'd0);
		send_setup(4'd0, make_type(DIR_IN, ucrd_pkg::KIND_STANDARD), ucrd_pkg::REQ_GET_DESCRIPTOR,
			{ucrd_pkg::DESC_DEVICE, 8'd0}, 16'h0000, 16'd64);
		send_setup(4'd0, make_type(DIR_IN, ucrd_pkg::KIND_STANDARD), ucrd_pkg::REQ_GET_DESCRIPTOR,
			{ucrd_pkg::DESC_CONFIG, 8'd0}, 16'h0000, 16'hFFFF);
		send_setup(4'd0, make_type(DIR_IN, ucrd_pkg::KIND_STANDARD), ucrd_pkg::REQ_GET_DESCRIPTOR,
			{ucrd_pkg::DESC_QUALIFIER, 8'd0}, 16'h0000, 16'd9);
		send_setup(4'd0, make_type(DIR_IN, ucrd_pkg::KIND_STANDARD), ucrd_pkg::REQ_GET_DESCRIPTOR,
			{ucrd_pkg::DESC_STRING, 8'd0}, 16'h0409, 16'd255);
		send_setup(4'd0, make_type(DIR_IN, ucrd_pkg::KIND_STANDARD), ucrd_pkg::REQ_GET_DESCRIPTOR,
			{ucrd_pkg::DESC_STRING, 8'd3}, 16'h0409, 16'd255);
		// string index past the table, unknown descriptor type
		send_setup(4'd0, make_type(DIR_IN, ucrd_pkg::KIND_STANDARD), ucrd_pkg::REQ_GET_DESCRIPTOR,
			{ucrd_pkg::DESC_STRING, 8'd4}, 16'h0409, 16'd255);
		send_setup(4'd0, make_type(DIR_IN, ucrd_pkg::KIND_STANDARD), ucrd_pkg::REQ_GET_DESCRIPTOR,
			{DESC_UNKNOWN, 8'd0}, 16'h0000, 16'd8);
		send_setup(4'd0, make_type(DIR_IN, ucrd_pkg::KIND_STANDARD),
			ucrd_pkg::REQ_GET_CONFIGURATION, 16'h0000, 16'h0000, 16'd4);
		send_setup(4'd0, make_type(DIR_OUT, ucrd_pkg::KIND_STANDARD),
			ucrd_pkg::REQ_SET_CONFIGURATION, 16'h0001, 16'h0000, 16'd0);
		send_setup(4'd0, make_type(DIR_OUT, ucrd_pkg::KIND_STANDARD),
			ucrd_pkg::REQ_SET_CONFIGURATION, 16'h0002, 16'h0000, 16'd0);
		send_setup(4'd0, make_type(DIR_OUT, ucrd_pkg::KIND_STANDARD),
			ucrd_pkg::REQ_SET_CONFIGURATION, 16'h0000, 16'h0000, 16'd0);
		send_setup(4'd0, make_type(DIR_IN, ucrd_pkg::KIND_STANDARD), ucrd_pkg::REQ_GET_INTERFACE,
			16'h0000, 16'h0000, 16'd5);
		send_setup(4'd0, make_type(DIR_OUT, ucrd_pkg::KIND_STANDARD), ucrd_pkg::REQ_SET_INTERFACE,
			16'h12FF, 16'h0000, 16'd0);
		send_setup(4'd0, make_type(DIR_IN, ucrd_pkg::KIND_STANDARD), REQ_CLEAR_FEATURE,
			16'h0000, 16'h0000, 16'd2);
		send_setup(4'd0, make_type(DIR_OUT, ucrd_pkg::KIND_CLASS), ucrd_pkg::REQ_SEND_ENCAP,
			16'h0000, 16'h0000, 16'd8);
		send_setup(4'd0, make_type(DIR_IN, ucrd_pkg::KIND_CLASS), ucrd_pkg::REQ_GET_ENCAP,
			16'h0000, 16'h0000, 16'd8);
		send_setup(4'd0, make_type(DIR_OUT, ucrd_pkg::KIND_CLASS), ucrd_pkg::REQ_SET_LINE_CODING,
			16'h0000, 16'h0000, 16'd7);
		send_setup(4'd0, make_type(DIR_IN, ucrd_pkg::KIND_CLASS), ucrd_pkg::REQ_GET_LINE_CODING,
			16'h0000, 16'h0000, 16'd0);
		send_setup(4'd0, make_type(DIR_OUT, ucrd_pkg::KIND_CLASS), ucrd_pkg::REQ_SET_CTRL_LINE,
			16'h0003, 16'h0000, 16'd0);
		send_setup(4'd0, make_type(DIR_OUT, ucrd_pkg::KIND_CLASS), ucrd_pkg::REQ_SEND_BREAK,
			16'hFFFF, 16'h0000, 16'd0);
		send_setup(4'd0, make_type(DIR_OUT, ucrd_pkg::KIND_CLASS), REQ_CLASS_UNKNOWN,
			16'h0000, 16'h0000, 16'd0);
		send_setup(4'd0, make_type(DIR_IN, KIND_VENDOR), ucrd_pkg::REQ_GET_STATUS,
			16'h0000, 16'h0000, 16'd2);
		send_setup(4'd0, make_type(DIR_OUT, KIND_RESERVED), ucrd_pkg::REQ_SET_ADDRESS,
			16'h0011, 16'h0000, 16'd0);
	endtask

	// stimulus: reset, three idle profiles, drain, verdict
	initial begin
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		endpoint_num   = 4'd0;
		request_type   = 8'd0;
		request_code   = 8'd0;
		request_value  = 16'd0;
		request_index  = 16'd0;
		request_length = 16'd0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					sender_idle_pct = 9;
					recv_idle_pct   = 77;
				end
				1: begin
					sender_idle_pct = 77;
					recv_idle_pct   = 9;
				end
				default: begin
					sender_idle_pct = 0;
					recv_idle_pct   = 0;
				end
			endcase
			if (phase == 0)
				send_directed_setups();
			for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
				send_random_setup();
				if (n == RANDOM_PER_PHASE / 2)
					drain_replies();
			end
			drain_replies();
		end

		// pipeline is two deep; give it room to show a stray beat
		repeat (8) @(negedge clk);

		$display("Sent %0d setup packets (standard, class, vendor, reserved, noise)", packets_sent);
		$display("under three idle profiles; %0d replies checked field by field.",
			replies_checked);
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
